// ===== design/wvg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvg_pkg
// Shared types and constants of the waypoint velocity generator.
// ----------------------------------------------------------------------------
package wvg_pkg;

  // input beat
  typedef struct packed {
    logic              kind;
    logic [3:0]        slot;
    logic              last_load;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } in_t;

  // result beat
  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [4:0]         target_slot;
    logic               all_reached;
  } out_t;

  // item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_PREF_SPEED = 2'd0,
    REG_GOAL_TOL   = 2'd1,
    REG_INV_DT     = 2'd2,
    REG_SLOW_RAD   = 2'd3
  } reg_idx_t;

  // reset values of the registers
  localparam logic [30:0] PREF_SPEED_RST = 31'd65536;
  localparam logic [30:0] GOAL_TOL_RST   = 31'd6554;
  localparam logic [30:0] INV_DT_RST     = 31'd655360;
  localparam logic [30:0] SLOW_RAD_RST   = 31'd131072;

  // squared near-zero threshold (66 units squared)
  localparam logic [65:0] NEAR_ZERO_SQ = 66'd4356;

  // iteration counts of the shared units
  localparam int ROOT_STEPS = 33;
  localparam int DIV_STEPS  = 31;

  // multiplier operations
  typedef enum logic [2:0] {
    OP_SQ   = 3'd0,
    OP_TOL  = 3'd1,
    OP_SLOW = 3'd2,
    OP_CAP  = 3'd3,
    OP_VEL  = 3'd4
  } op_t;

endpackage

// ===== design/wvg_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvg_store
// Waypoint memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wvg_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [95:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [95:0]   rd_data
);

  logic [95:0] mem [DEPTH];
  logic [95:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/wvg_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvg_mul
// Shared 33 x 33 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module wvg_mul (
  input  logic        clk,
  input  logic [32:0] op_a,
  input  logic [32:0] op_b,
  output logic [65:0] prod
);

  logic [65:0] prod_r;

  // one product per cycle
  always_ff @(posedge clk) begin
    prod_r <= 66'(op_a) * 66'(op_b);
  end

  assign prod = prod_r;

endmodule

// ===== design/wvg_root.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvg_root
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module wvg_root (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [65:0] radicand,
  output logic        done,
  output logic [32:0] root
);

  logic [65:0] sv_r,   sv_nxt;
  logic [35:0] rem_r,  rem_nxt;
  logic [32:0] root_r, root_nxt;
  logic [5:0]  cnt_r,  cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [35:0] rem_cur;
  logic [35:0] trial;

  // one bit pair per cycle
  always_comb begin
    sv_nxt   = sv_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_cur  = {rem_r[33:0], sv_r[65:64]};
    trial    = {1'b0, root_r, 2'b01};
    if (start) begin
      sv_nxt   = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = 6'(wvg_pkg::ROOT_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      sv_nxt = {sv_r[63:0], 2'b00};
      if (rem_cur >= trial) begin
        rem_nxt  = rem_cur - trial;
        root_nxt = {root_r[31:0], 1'b1};
      end else begin
        rem_nxt  = rem_cur;
        root_nxt = {root_r[31:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sv_r   <= sv_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== design/wvg_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvg_div
// Restoring divider, one quotient bit per cycle; the quotient is known to
// stay below 2^31, so the high part of the dividend starts as the remainder.
// ----------------------------------------------------------------------------
module wvg_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [32:0] den,
  output logic        done,
  output logic [30:0] quo
);

  logic [32:0] rem_r, rem_nxt;
  logic [30:0] nb_r,  nb_nxt;
  logic [30:0] q_r,   q_nxt;
  logic [32:0] den_r, den_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] trial;

  // shift in one dividend bit, subtract when it fits
  always_comb begin
    rem_nxt  = rem_r;
    nb_nxt   = nb_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, nb_r[30]};
    if (start) begin
      rem_nxt  = num[63:31];
      nb_nxt   = num[30:0];
      q_nxt    = '0;
      den_nxt  = den;
      cnt_nxt  = 5'(wvg_pkg::DIV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      nb_nxt = {nb_r[29:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = 33'(trial - {1'b0, den_r});
        q_nxt   = {q_r[29:0], 1'b1};
      end else begin
        rem_nxt = trial[32:0];
        q_nxt   = {q_r[29:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    nb_r  <= nb_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ===== design/waypoint_velocity_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_velocity_generator
// Load beats fill a waypoint memory; step beats return the preferred
// velocity toward the current waypoint and advance it once reached.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one beat per item, kind selects waypoint load or simulation step.
//   out_* : exactly one result beat per item, held until out_ready.
//   cfg_* : register writes (speed, tolerance, 1/dt, slow radius), always
//           ready; write them only while the block is idle.
// Throughput and sequence
//   Items are handled one at a time; in_ready is high only when idle.
//   A load, or a step with no waypoint left, shows its result in the cycle
//   after acceptance. A step ending with zero velocity after the distance
//   tests passes ST_RD, ST_DIF, the squaring, tolerance and slow-radius
//   products and ST_DEC; a full step adds the square root, three divisions
//   and one more product inside the slow radius, on one shared multiplier.
// Reset
//   Synchronous, active low: waypoint count 0, index 1, registers to their
//   defaults. The waypoint memory is not cleared.
// Stall
//   While out_ready is low the result holds and no new item is taken.
// ----------------------------------------------------------------------------
module waypoint_velocity_generator #(
  parameter int WAYPOINTS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  wvg_pkg::in_t     in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output wvg_pkg::out_t    out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  localparam int AW = (WAYPOINTS > 1) ? $clog2(WAYPOINTS) : 1;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_RD   = 9'b000000010,
    ST_DIF  = 9'b000000100,
    ST_MUL  = 9'b000001000,
    ST_ACC  = 9'b000010000,
    ST_DEC  = 9'b000100000,
    ST_ROOT = 9'b001000000,
    ST_DIV  = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_t;

  state_t          state_r, state_nxt;
  wvg_pkg::op_t    op_r, op_nxt;
  logic [1:0]      idx_r, idx_nxt;
  logic [4:0]      count_r, count_nxt;
  logic [4:0]      cur_r, cur_nxt;
  logic [30:0]     pref_r, tol_r, inv_dt_r, slow_r;
  logic [31:0]     pos_r [3];
  logic [32:0]     mag_r [3];
  logic [32:0]     mag_nxt [3];
  logic            neg_r [3];
  logic            neg_nxt [3];
  logic [31:0]     vel_r [3];
  logic [31:0]     vel_nxt [3];
  logic [65:0]     s_r, s_nxt;
  logic            tol_hit_r, tol_hit_nxt;
  logic            slow_in_r, slow_in_nxt;
  logic [32:0]     dist_r, dist_nxt;
  logic [30:0]     speed_r, speed_nxt;

  logic            accept;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic            rd_en;
  logic [95:0]     rd_data;
  logic [31:0]     tgt [3];
  logic [32:0]     diff [3];
  logic [32:0]     mul_a, mul_b;
  logic [65:0]     prod;
  logic            root_start, root_done;
  logic [32:0]     root_val;
  logic            div_start, div_done;
  logic [30:0]     quo;
  logic [49:0]     cap;
  logic [4:0]      cur_inc;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign cfg_ready = 1'b1;

  // waypoint load write
  assign wr_en   = accept && (in_data.kind == wvg_pkg::KIND_LOAD)
                   && (int'(in_data.slot) < WAYPOINTS);
  assign wr_addr = AW'(in_data.slot);

  wvg_store #(.DEPTH(WAYPOINTS), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({in_data.coord_x, in_data.coord_y, in_data.coord_z}),
    .rd_en   (rd_en),
    .rd_addr (AW'(cur_r)),
    .rd_data (rd_data)
  );

  assign rd_en = (state_r == ST_RD);

  // target minus agent, exact in 33 bits
  assign tgt[0] = rd_data[95:64];
  assign tgt[1] = rd_data[63:32];
  assign tgt[2] = rd_data[31:0];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = {tgt[i][31], tgt[i]} - {pos_r[i][31], pos_r[i]};
    end
  end

  // operand select of the shared multiplier
  always_comb begin
    unique case (op_r)
      wvg_pkg::OP_SQ: begin
        mul_a = mag_r[idx_r];
        mul_b = mag_r[idx_r];
      end
      wvg_pkg::OP_TOL: begin
        mul_a = {2'b00, tol_r};
        mul_b = {2'b00, tol_r};
      end
      wvg_pkg::OP_SLOW: begin
        mul_a = {2'b00, slow_r};
        mul_b = {2'b00, slow_r};
      end
      wvg_pkg::OP_CAP: begin
        mul_a = dist_r;
        mul_b = {2'b00, inv_dt_r};
      end
      wvg_pkg::OP_VEL: begin
        mul_a = mag_r[idx_r];
        mul_b = {2'b00, speed_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  wvg_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  wvg_root u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (s_r),
    .done     (root_done),
    .root     (root_val)
  );

  wvg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod[63:0]),
    .den   (dist_r),
    .done  (div_done),
    .quo   (quo)
  );

  assign cap     = prod[65:16];
  assign cur_inc = cur_r + 5'd1;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    idx_nxt     = idx_r;
    count_nxt   = count_r;
    cur_nxt     = cur_r;
    s_nxt       = s_r;
    tol_hit_nxt = tol_hit_r;
    slow_in_nxt = slow_in_r;
    dist_nxt    = dist_r;
    speed_nxt   = speed_r;
    root_start  = 1'b0;
    div_start   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i] = mag_r[i];
      neg_nxt[i] = neg_r[i];
      vel_nxt[i] = vel_r[i];
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          for (int i = 0; i < 3; i++) begin
            vel_nxt[i] = '0;
          end
          if (in_data.kind == wvg_pkg::KIND_LOAD) begin
            if (wr_en && in_data.last_load) begin
              count_nxt = {1'b0, in_data.slot} + 5'd1;
              cur_nxt   = 5'd1;
            end
            state_nxt = ST_OUT;
          end else if (cur_r < count_r) begin
            state_nxt = ST_RD;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_DIF;
      end
      ST_DIF: begin
        for (int i = 0; i < 3; i++) begin
          neg_nxt[i] = diff[i][32];
          mag_nxt[i] = diff[i][32] ? (33'd0 - diff[i]) : diff[i];
        end
        s_nxt     = '0;
        op_nxt    = wvg_pkg::OP_SQ;
        idx_nxt   = 2'd0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        unique case (op_r)
          wvg_pkg::OP_SQ: begin
            s_nxt     = s_r + prod;
            state_nxt = ST_MUL;
            if (idx_r == 2'd2) begin
              op_nxt = wvg_pkg::OP_TOL;
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end
          wvg_pkg::OP_TOL: begin
            tol_hit_nxt = (s_r < prod);
            op_nxt      = wvg_pkg::OP_SLOW;
            state_nxt   = ST_MUL;
          end
          wvg_pkg::OP_SLOW: begin
            slow_in_nxt = (s_r < prod);
            state_nxt   = ST_DEC;
          end
          wvg_pkg::OP_CAP: begin
            speed_nxt = (cap < {19'd0, pref_r}) ? cap[30:0] : pref_r;
            op_nxt    = wvg_pkg::OP_VEL;
            idx_nxt   = 2'd0;
            state_nxt = ST_MUL;
          end
          wvg_pkg::OP_VEL: begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
          default: begin
            state_nxt = ST_OUT;
          end
        endcase
      end
      ST_DEC: begin
        if (tol_hit_r) begin
          cur_nxt = cur_inc;
        end
        if (tol_hit_r && (cur_inc >= count_r)) begin
          state_nxt = ST_OUT;
        end else if (s_r < wvg_pkg::NEAR_ZERO_SQ) begin
          state_nxt = ST_OUT;
        end else begin
          root_start = 1'b1;
          state_nxt  = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          dist_nxt  = root_val;
          state_nxt = ST_MUL;
          if (slow_in_r) begin
            op_nxt = wvg_pkg::OP_CAP;
          end else begin
            speed_nxt = pref_r;
            op_nxt    = wvg_pkg::OP_VEL;
            idx_nxt   = 2'd0;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          vel_nxt[idx_r] = neg_r[idx_r] ? (32'd0 - {1'b0, quo}) : {1'b0, quo};
          if (idx_r == 2'd2) begin
            state_nxt = ST_OUT;
          end else begin
            idx_nxt   = idx_r + 2'd1;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= wvg_pkg::OP_SQ;
      idx_r   <= '0;
      count_r <= '0;
      cur_r   <= 5'd1;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
      cur_r   <= cur_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pref_r   <= wvg_pkg::PREF_SPEED_RST;
      tol_r    <= wvg_pkg::GOAL_TOL_RST;
      inv_dt_r <= wvg_pkg::INV_DT_RST;
      slow_r   <= wvg_pkg::SLOW_RAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (wvg_pkg::reg_idx_t'(cfg_index))
        wvg_pkg::REG_PREF_SPEED: pref_r   <= cfg_data[30:0];
        wvg_pkg::REG_GOAL_TOL:   tol_r    <= cfg_data[30:0];
        wvg_pkg::REG_INV_DT:     inv_dt_r <= cfg_data[30:0];
        wvg_pkg::REG_SLOW_RAD:   slow_r   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r[0] <= in_data.coord_x;
      pos_r[1] <= in_data.coord_y;
      pos_r[2] <= in_data.coord_z;
    end
    for (int i = 0; i < 3; i++) begin
      mag_r[i] <= mag_nxt[i];
      neg_r[i] <= neg_nxt[i];
      vel_r[i] <= vel_nxt[i];
    end
    s_r       <= s_nxt;
    tol_hit_r <= tol_hit_nxt;
    slow_in_r <= slow_in_nxt;
    dist_r    <= dist_nxt;
    speed_r   <= speed_nxt;
  end

  // result beat
  assign out_data.vel_x       = vel_r[0];
  assign out_data.vel_y       = vel_r[1];
  assign out_data.vel_z       = vel_r[2];
  assign out_data.target_slot = cur_r;
  assign out_data.all_reached = (cur_r >= count_r);

endmodule
